@@ sv/rptw_pkg.sv @@
// Shared sizes, codes and types for the radix page table walker.
// No dependencies; every other file of the block but rptw_frame_ram refers to this package.
package rptw_pkg;

	// Table geometry.
	localparam int FRAMES     = 64;
	localparam int LEVELS     = 5;
	localparam int INDEX_BITS = 9;

	// Field widths fixed by the interface.
	localparam int PAGE_W      = 52;
	localparam int VPN_W       = 45;
	localparam int ENTRY_W     = PAGE_W + 1;
	localparam int ROOT_W      = 6;
	localparam int FREE_W      = 7;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 1;

	// Frame store addressing.
	localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int ENTRIES    = 1 << INDEX_BITS;
	localparam int DEPTH      = FRAMES * ENTRIES;
	localparam int ADDR_BITS  = FRAME_BITS + INDEX_BITS;

	// Walk bookkeeping.
	localparam int WALK_W    = LEVELS * INDEX_BITS;
	localparam int VPN_PAD_W = (WALK_W > VPN_W) ? WALK_W : VPN_W;
	localparam int LVL_W     = $clog2(LEVELS + 1);
	localparam int ALLOC_W   = $clog2(FRAMES + 1);
	localparam int NEXT_W    = ((FREE_W > ALLOC_W) ? FREE_W : ALLOC_W) + 1;

	// Frame number reduction unit.
	localparam bit FRAMES_POW2 = ((FRAMES & (FRAMES - 1)) == 0);
	localparam int MOD_CHUNK   = 8;
	localparam int MOD_CHUNKS  = (PAGE_W + MOD_CHUNK - 1) / MOD_CHUNK;
	localparam int MOD_PAD_W   = MOD_CHUNKS * MOD_CHUNK;
	localparam int MOD_CNT_W   = $clog2(MOD_CHUNKS + 1);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_FRAME = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_FREE = 1'd1;

	// Operation and status codes.
	localparam logic OP_QUERY         = 1'b0;
	localparam logic OP_UPDATE        = 1'b1;
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NO_FRAMES = 1'b1;

	// One frame store entry: page or frame number over a valid bit.
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              valid;
	} entry_t;

	// Request to and answer from the frame number reduction unit.
	typedef struct packed {
		logic              start;
		logic [PAGE_W-1:0] value;
	} mod_req_t;

	typedef struct packed {
		logic                  done;
		logic [FRAME_BITS-1:0] frame;
	} mod_rsp_t;

endpackage

@@ sv/rptw_chan_if.sv @@
// Request and result channels of the radix page table walker.
// Depends on rptw_pkg for the field widths.
interface rptw_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [rptw_pkg::VPN_W-1:0]  virtual_page;
	logic                        unmap;
	logic [rptw_pkg::PAGE_W-1:0] target_page;

	modport source (output valid, operation, virtual_page, unmap, target_page, input ready);
	modport sink (input valid, operation, virtual_page, unmap, target_page, output ready);
endinterface

interface rptw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [rptw_pkg::PAGE_W-1:0] mapped_page;
	logic                        status;

	modport source (output valid, found, mapped_page, status, input ready);
	modport sink (input valid, found, mapped_page, status, output ready);
endinterface

@@ sv/radix_page_table_walker.sv @@
// Top level of the radix page table walker: walk sequencer, allocator,
// configuration registers and result register. Depends on rptw_pkg,
// rptw_chan_if, rptw_frame_ram and rptw_frame_mod.
//
// Channel   Direction  Beat contents
// req       in         operation, virtual_page, unmap, target_page
// rsp       out        found, mapped_page, status
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// An item is taken in the idle state; each level then runs a frame reduction,
// one memory read and a step to look and write back, and the result is handed
// over in a final state. A walk that ends early visits fewer levels. With a
// frame count that is not a power of two the reduction folds the frame number
// eight bits at a time instead of masking it. The single store port sets this order.
// After reset a clearing pass over all FRAMES * 512 entries (32768 by default)
// zeroes the store; no beat is taken meanwhile, configuration writes are.
// A stalled result waits in the output register while the next beat is taken.
module radix_page_table_walker (
	input  logic                             clk,
	input  logic                             arst_n,
	rptw_req_if.sink                         req,
	rptw_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [rptw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_LOOK,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [rptw_pkg::ADDR_BITS-1:0]     clr_q;
	logic [rptw_pkg::ROOT_W-1:0]        root_q;
	logic [rptw_pkg::FREE_W-1:0]        first_free_q;
	logic [rptw_pkg::ALLOC_W-1:0]       alloc_q;
	logic [rptw_pkg::LVL_W-1:0]         lvl_q;
	logic [rptw_pkg::WALK_W-1:0]        path_q;
	logic [rptw_pkg::FRAME_BITS-1:0]    frame_q;
	logic                               op_q;
	logic                               unmap_q;
	logic [rptw_pkg::PAGE_W-1:0]        target_q;
	logic                               res_found_q;
	logic [rptw_pkg::PAGE_W-1:0]        res_page_q;
	logic                               res_status_q;
	logic                               out_valid_q;
	logic                               out_found_q;
	logic [rptw_pkg::PAGE_W-1:0]        out_page_q;
	logic                               out_status_q;
	rptw_pkg::mod_req_t                 mod_req_q;
	rptw_pkg::mod_rsp_t                 mod_rsp;

	logic [rptw_pkg::VPN_PAD_W-1:0]     vpn_ext;
	logic [rptw_pkg::INDEX_BITS-1:0]    idx;
	logic [rptw_pkg::NEXT_W-1:0]        next_frame;
	logic                               exhausted;
	logic                               inner;
	logic                               leaf_hit;
	logic                               no_frames;
	logic                               mod_start;
	logic                               ram_we;
	logic                               ram_re;
	logic [rptw_pkg::ADDR_BITS-1:0]     ram_addr;
	rptw_pkg::entry_t                   ram_wdata;
	rptw_pkg::entry_t                   entry;
	logic [rptw_pkg::ENTRY_W-1:0]       ram_rdata;

	// Frame store and the frame number reduction unit.
	rptw_frame_ram #(
		.DEPTH  (rptw_pkg::DEPTH),
		.WIDTH  (rptw_pkg::ENTRY_W),
		.ADDR_W (rptw_pkg::ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	rptw_frame_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req_q),
		.rsp    (mod_rsp)
	);

	// Walk path, allocator candidate and level decode.
	assign vpn_ext    = rptw_pkg::VPN_PAD_W'(req.virtual_page);
	assign idx        = path_q[rptw_pkg::WALK_W-1 -: rptw_pkg::INDEX_BITS];
	assign next_frame = rptw_pkg::NEXT_W'(first_free_q) + rptw_pkg::NEXT_W'(alloc_q);
	assign exhausted  = next_frame >= rptw_pkg::NEXT_W'(rptw_pkg::FRAMES);
	assign inner      = lvl_q != rptw_pkg::LVL_W'(rptw_pkg::LEVELS);
	assign entry      = rptw_pkg::entry_t'(ram_rdata);

	// Outcome of the entry being looked at, and when a reduction starts.
	assign leaf_hit  = !inner && op_q == rptw_pkg::OP_QUERY && entry.valid;
	assign no_frames = inner && !entry.valid && op_q == rptw_pkg::OP_UPDATE && exhausted;
	assign mod_start = (state_q == S_IDLE && req.valid) ||
		(state_q == S_LOOK && inner &&
			(entry.valid || (op_q == rptw_pkg::OP_UPDATE && !exhausted)));

	// Store port: clearing sweep, level reads and write-back of the looked-at entry.
	always_comb begin
		ram_re    = (state_q == S_READ);
		ram_we    = 1'b0;
		ram_addr  = {frame_q, idx};
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we   = 1'b1;
			ram_addr = clr_q;
		end else if (state_q == S_LOOK && op_q == rptw_pkg::OP_UPDATE) begin
			if (inner) begin
				ram_we          = !entry.valid && !exhausted;
				ram_wdata.page  = rptw_pkg::PAGE_W'(next_frame);
				ram_wdata.valid = 1'b1;
			end else if (unmap_q) begin
				ram_we          = 1'b1;
				ram_wdata.page  = entry.page;
				ram_wdata.valid = 1'b0;
			end else begin
				ram_we          = 1'b1;
				ram_wdata.page  = target_q;
				ram_wdata.valid = 1'b1;
			end
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.mapped_page = out_page_q;
	assign rsp.status      = out_status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q       <= '0;
			first_free_q <= rptw_pkg::FREE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rptw_pkg::CFG_ROOT_FRAME: root_q       <= cfg_data[rptw_pkg::ROOT_W-1:0];
				rptw_pkg::CFG_FIRST_FREE: first_free_q <= cfg_data[rptw_pkg::FREE_W-1:0];
			endcase
		end
	end

	// Walk sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			alloc_q     <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			mod_req_q   <= '0;
		end else begin
			mod_req_q.start <= mod_start;
			// A taken result empties the output register unless a new one replaces it.
			if (rsp.valid && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == rptw_pkg::ADDR_BITS'(rptw_pkg::DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q            <= req.operation;
						unmap_q         <= req.unmap;
						target_q        <= req.target_page;
						path_q          <= vpn_ext[rptw_pkg::WALK_W-1:0];
						lvl_q           <= rptw_pkg::LVL_W'(1);
						mod_req_q.value <= rptw_pkg::PAGE_W'(root_q);
						state_q         <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						frame_q <= mod_rsp.frame;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					res_found_q  <= leaf_hit;
					res_page_q   <= leaf_hit ? entry.page : '0;
					res_status_q <= no_frames ? rptw_pkg::STATUS_NO_FRAMES
						: rptw_pkg::STATUS_OK;
					if (inner) begin
						if (entry.valid) begin
							mod_req_q.value <= entry.page;
							lvl_q           <= lvl_q + 1'b1;
							path_q          <= path_q << rptw_pkg::INDEX_BITS;
							state_q         <= S_MOD;
						end else if (op_q == rptw_pkg::OP_QUERY || exhausted) begin
							state_q <= S_DONE;
						end else begin
							alloc_q         <= alloc_q + 1'b1;
							mod_req_q.value <= rptw_pkg::PAGE_W'(next_frame);
							lvl_q           <= lvl_q + 1'b1;
							path_q          <= path_q << rptw_pkg::INDEX_BITS;
							state_q         <= S_MOD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hand over once the output register is free or being emptied.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_found_q  <= res_found_q;
						out_page_q   <= res_page_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/rptw_frame_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; holds the frame store of the walker.
module rptw_frame_ram #(
	parameter int DEPTH  = 32768,
	parameter int WIDTH  = 53,
	parameter int ADDR_W = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access a cycle: a write, or a read whose data appears next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ sv/rptw_frame_mod.sv @@
// Reduces a page-wide frame number modulo the number of frames.
// Depends on rptw_pkg; a mask when the frame count is a power of two,
// otherwise eight bits a cycle by restoring reduction.
module rptw_frame_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  rptw_pkg::mod_req_t req,
	output rptw_pkg::mod_rsp_t rsp
);

	localparam int R_W = rptw_pkg::FRAME_BITS + 1;

	logic                                busy_q;
	logic [rptw_pkg::MOD_CNT_W-1:0]      cnt_q;
	logic [rptw_pkg::MOD_PAD_W-1:0]      value_q;
	logic [rptw_pkg::FRAME_BITS-1:0]     r_q;
	logic [rptw_pkg::FRAME_BITS-1:0]     r_next;
	logic [R_W-1:0]                      trial;
	logic [rptw_pkg::MOD_CHUNK-1:0]      chunk;
	logic                                done;

	// Fold the top chunk into the running remainder, one bit a step.
	always_comb begin
		r_next = r_q;
		trial  = '0;
		chunk  = value_q[rptw_pkg::MOD_PAD_W-1 -: rptw_pkg::MOD_CHUNK];
		for (int i = 0; i < rptw_pkg::MOD_CHUNK; i++) begin
			trial = {r_next, chunk[rptw_pkg::MOD_CHUNK-1-i]};
			if (trial >= R_W'(rptw_pkg::FRAMES)) begin
				trial = trial - R_W'(rptw_pkg::FRAMES);
			end
			r_next = trial[rptw_pkg::FRAME_BITS-1:0];
		end
	end

	assign done = busy_q &&
		(rptw_pkg::FRAMES_POW2 || (cnt_q == rptw_pkg::MOD_CNT_W'(rptw_pkg::MOD_CHUNKS)));

	assign rsp.done  = done;
	assign rsp.frame = rptw_pkg::FRAMES_POW2 ? value_q[rptw_pkg::FRAME_BITS-1:0] : r_q;

	// Control of the reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand and remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			value_q <= rptw_pkg::MOD_PAD_W'(req.value);
			r_q     <= '0;
		end else if (busy_q && !done) begin
			value_q <= value_q << rptw_pkg::MOD_CHUNK;
			r_q     <= r_next;
		end
	end

endmodule

@@ sv/rptw_checker.sv @@
// Port-level checks for the radix page table walker, bound to its top level.
// Depends on rptw_pkg and radix_page_table_walker.
module rptw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_found,
	input logic [rptw_pkg::PAGE_W-1:0] rsp_mapped_page,
	input logic                        rsp_status
);

	// A stalled result beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped_page)
			&& $stable(rsp_found) && $stable(rsp_status))
		else $error("result beat changed while stalled");

	// A result that reports no mapping carries page zero.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_mapped_page == '0)
		else $error("page reported without a mapping");

	// A query result and an allocation failure never come together.
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_status))
		else $error("found and out_of_frames both set");

	// One walk at a time: the cycle after a beat is taken the port is closed.
	a_one_walk: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during a walk");

	// The clearing pass starts right after reset and keeps the port closed.
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("request port open during the clearing pass");

endmodule

bind radix_page_table_walker rptw_checker u_rptw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_mapped_page (rsp.mapped_page),
	.rsp_status      (rsp.status)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for radix_page_table_walker: random and directed walks with a
// software copy of the frame store. Depends on rptw_pkg, rptw_chan_if and radix_page_table_walker.
module tb_top;
	import rptw_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	// One request beat and one result beat, as seen on the channels.
	typedef struct packed {
		logic              operation;
		logic [VPN_W-1:0]  virtual_page;
		logic              unmap;
		logic [PAGE_W-1:0] target_page;
	} walk_t;

	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] mapped_page;
		logic              status;
	} answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	rptw_req_if req_ch ();
	rptw_rsp_if rsp_ch ();

	radix_page_table_walker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Software copy of the walker state and its registers.
	entry_t            store_copy [DEPTH];
	int unsigned       frames_handed;
	logic [ROOT_W-1:0] root_copy;
	logic [FREE_W-1:0] first_free_copy;

	// Bench bookkeeping.
	walk_t             walks_to_send [$];
	answer_t           pending_answers [$];
	logic [VPN_W-1:0]  mapped_pages [$];
	int unsigned       queued_total;
	int unsigned       answers_seen;
	int unsigned       walks_accepted;
	int unsigned       mismatches;
	int unsigned       cycle_count = 0;
	int unsigned       send_pause, send_calm;
	int unsigned       take_pause, take_calm;
	int unsigned       hold_left, next_hold_at;
	walk_t             taken_walk;
	walk_t             next_walk;
	answer_t           oldest_answer;

	// Walk the copied table for one request and return the answer the block should give.
	function automatic answer_t walk_page_table(walk_t w);
		answer_t               ans;
		int unsigned           frame;
		int unsigned           slot;
		int unsigned           next_frame;
		logic [INDEX_BITS-1:0] idx;
		ans = '0;
		ans.status = STATUS_OK;
		frame = root_copy;
		// Inner levels, most significant index group first.
		for (int lvl = 1; lvl < LEVELS; lvl++) begin
			idx = INDEX_BITS'(w.virtual_page >> ((LEVELS - lvl) * INDEX_BITS));
			slot = (frame % FRAMES) * ENTRIES + idx;
			if (!store_copy[slot].valid) begin
				if (w.operation == OP_QUERY)
					return ans;
				next_frame = first_free_copy + frames_handed;
				if (next_frame >= FRAMES) begin
					ans.status = STATUS_NO_FRAMES;
					return ans;
				end
				frames_handed++;
				store_copy[slot].page  = PAGE_W'(next_frame);
				store_copy[slot].valid = 1'b1;
			end
			frame = 32'(store_copy[slot].page % FRAMES);
		end
		// Leaf level.
		idx = INDEX_BITS'(w.virtual_page);
		slot = (frame % FRAMES) * ENTRIES + idx;
		if (w.operation == OP_QUERY) begin
			if (store_copy[slot].valid) begin
				ans.found       = 1'b1;
				ans.mapped_page = store_copy[slot].page;
			end
		end else if (w.unmap) begin
			store_copy[slot].valid = 1'b0;
		end else begin
			store_copy[slot].page  = w.target_page;
			store_copy[slot].valid = 1'b1;
		end
		return ans;
	endfunction

	// Pause before the next beat: mostly random, with runs of back-to-back beats.
	function automatic int unsigned pick_pause(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic walk_t make_walk(logic op, logic [VPN_W-1:0] vpn, logic unmap,
			logic [PAGE_W-1:0] target);
		walk_t w;
		w.operation    = op;
		w.virtual_page = vpn;
		w.unmap        = unmap;
		w.target_page  = target;
		return w;
	endfunction

	// Random walk: mostly pages near ones already mapped, so that walks reach the leaves.
	function automatic walk_t random_walk();
		walk_t            w;
		int unsigned      pick;
		logic [VPN_W-1:0] vpn;
		pick = $urandom_range(0, 99);
		vpn = VPN_W'({$urandom, $urandom});
		if (mapped_pages.size() != 0 && pick >= 15) begin
			vpn = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
			if (pick < 55)
				vpn[INDEX_BITS-1:0] = INDEX_BITS'($urandom);
			else if (pick < 70)
				vpn[2*INDEX_BITS-1:0] = (2*INDEX_BITS)'($urandom);
		end
		w.operation    = $urandom_range(0, 99) < 45 ? OP_QUERY : OP_UPDATE;
		w.virtual_page = vpn;
		w.unmap        = ($urandom_range(0, 5) == 0);
		case ($urandom_range(0, 9))
			0: w.target_page = '0;
			1: w.target_page = '1;
			default: w.target_page = PAGE_W'({$urandom, $urandom});
		endcase
		return w;
	endfunction

	task automatic queue_walk(walk_t w);
		walks_to_send.push_back(w);
		queued_total++;
		if (w.operation == OP_UPDATE && !w.unmap && mapped_pages.size() < 64)
			mapped_pages.push_back(w.virtual_page);
	endtask

	task automatic send_random(int count);
		repeat (count) queue_walk(random_walk());
	endtask

	// Register write while the walker is idle; the copy follows at once.
	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_ROOT_FRAME)
			root_copy = ROOT_W'(value);
		else
			first_free_copy = FREE_W'(value);
	endtask

	task automatic wait_drained();
		while (answers_seen != queued_total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic flag_error(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	// Request driver: offers queued walks and predicts each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.operation    <= OP_QUERY;
			req_ch.virtual_page <= '0;
			req_ch.unmap        <= 1'b0;
			req_ch.target_page  <= '0;
			walks_accepted      <= 0;
			send_pause = 0;
			send_calm  = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				taken_walk = make_walk(req_ch.operation, req_ch.virtual_page, req_ch.unmap,
					req_ch.target_page);
				pending_answers.push_back(walk_page_table(taken_walk));
				walks_accepted <= walks_accepted + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_pause != 0) begin
					send_pause--;
					req_ch.valid <= 1'b0;
				end else if (walks_to_send.size() != 0) begin
					next_walk = walks_to_send.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.operation    <= next_walk.operation;
					req_ch.virtual_page <= next_walk.virtual_page;
					req_ch.unmap        <= next_walk.unmap;
					req_ch.target_page  <= next_walk.target_page;
					send_pause = pick_pause(send_calm);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long result hold-offs, so that the walker fills up and stalls its request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= 150;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (walks_accepted >= next_hold_at) begin
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + 400;
		end
	end

	// Result monitor: each beat is checked against the oldest predicted answer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			answers_seen <= 0;
			take_pause = 0;
			take_calm  = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_seen <= answers_seen + 1;
				if (pending_answers.size() == 0) begin
					flag_error("unexpected result beat", '0, 64'(rsp_ch.mapped_page));
				end else begin
					oldest_answer = pending_answers.pop_front();
					if (rsp_ch.found !== oldest_answer.found)
						flag_error("found", 64'(oldest_answer.found), 64'(rsp_ch.found));
					if (rsp_ch.mapped_page !== oldest_answer.mapped_page)
						flag_error("mapped_page", 64'(oldest_answer.mapped_page),
							64'(rsp_ch.mapped_page));
					if (rsp_ch.status !== oldest_answer.status)
						flag_error("status", 64'(oldest_answer.status), 64'(rsp_ch.status));
				end
				take_pause = pick_pause(take_calm);
			end else if (take_pause != 0) begin
				take_pause--;
			end
			rsp_ch.ready <= (take_pause == 0) && (hold_left == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus sequence: reset, directed walks, then random phases under several settings.
	initial begin
		foreach (store_copy[i])
			store_copy[i] = '0;
		frames_handed   = 0;
		root_copy       = '0;
		first_free_copy = FREE_W'(1);
		queued_total    = 0;
		mismatches      = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_ROOT_FRAME;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walks with the reset settings: the first map takes frames 1 to 4,
		// so frame 4 becomes the leaf table of page zero.
		queue_walk(make_walk(OP_QUERY, '0, 1'b0, '0));
		queue_walk(make_walk(OP_UPDATE, '0, 1'b0, '0));
		queue_walk(make_walk(OP_QUERY, '0, 1'b0, '1));
		queue_walk(make_walk(OP_UPDATE, '1, 1'b0, '1));
		queue_walk(make_walk(OP_QUERY, '1, 1'b0, '0));
		queue_walk(make_walk(OP_UPDATE, '0, 1'b0, '1));
		queue_walk(make_walk(OP_QUERY, '0, 1'b0, '0));
		queue_walk(make_walk(OP_UPDATE, VPN_W'(1), 1'b0, {(PAGE_W/2){2'b01}}));
		queue_walk(make_walk(OP_UPDATE, VPN_W'(2), 1'b0, {(PAGE_W/2){2'b10}}));
		queue_walk(make_walk(OP_UPDATE, '0, 1'b1, '0));
		queue_walk(make_walk(OP_QUERY, '0, 1'b0, '0));
		queue_walk(make_walk(OP_QUERY, VPN_W'(1), 1'b1, '1));
		// Unmapping a leaf that is already invalid.
		queue_walk(make_walk(OP_UPDATE, '0, 1'b1, '1));
		// Unmapping through levels that do not exist yet still builds the inner tables.
		queue_walk(make_walk(OP_UPDATE, VPN_W'(64'h1AB << ((LEVELS - 1) * INDEX_BITS)),
			1'b1, '0));
		queue_walk(make_walk(OP_QUERY, VPN_W'(64'h1AB << ((LEVELS - 1) * INDEX_BITS)),
			1'b0, '0));
		// A query that runs out of valid entries part way down.
		queue_walk(make_walk(OP_QUERY, {VPN_W{1'b1}} << (2 * INDEX_BITS), 1'b0, '0));
		queue_walk(make_walk(OP_UPDATE, '0, 1'b0, PAGE_W'(3)));
		queue_walk(make_walk(OP_QUERY, VPN_W'(2), 1'b0, '0));
		wait_drained();

		send_random(250);
		wait_drained();

		// Highest root frame; allocator restarted at zero aliases frames already in use.
		write_register(CFG_ROOT_FRAME, FRAMES - 1);
		write_register(CFG_FIRST_FREE, 0);
		send_random(150);
		wait_drained();

		// Allocator start past the last frame: any new inner table runs out of frames.
		write_register(CFG_FIRST_FREE, FRAMES);
		queue_walk(make_walk(OP_UPDATE, VPN_W'({$urandom, $urandom}), 1'b0, '1));
		queue_walk(make_walk(OP_UPDATE, VPN_W'(1), 1'b0, PAGE_W'(5)));
		send_random(150);
		wait_drained();

		// Root on the leaf table of page zero: page numbers become frame numbers,
		// reduced modulo the frame count.
		write_register(CFG_ROOT_FRAME, 4);
		write_register(CFG_FIRST_FREE, $urandom_range(0, FRAMES));
		send_random(150);
		wait_drained();

		write_register(CFG_ROOT_FRAME, 0);
		write_register(CFG_FIRST_FREE, 1);
		send_random(100);
		wait_drained();

		if (mismatches == 0 && pending_answers.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
